// ===== hdl/http_request_header_parser_assert.svh =====
// assertion macros for the http request header parser
// used by http_request_header_parser.sv in hdl, no other dependencies
`ifndef HTTP_REQUEST_HEADER_PARSER_ASSERT_SVH
`define HTTP_REQUEST_HEADER_PARSER_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication, disabled in reset
`define HRP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: label");

// next-cycle implication, disabled in reset
`define HRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`else

`define HRP_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define HRP_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/hrp_pkg.sv =====
// shared types, constants and character tables for the http request parser
// no dependencies
package hrp_pkg;

  localparam int LINE_COUNT_BITS = 10;
  localparam int MAX_LEN_W       = 10;
  // width wide enough for both the line count plus one and the length limit
  localparam int CMP_W = (LINE_COUNT_BITS + 1 > MAX_LEN_W) ? LINE_COUNT_BITS + 1 : MAX_LEN_W;

  localparam logic [MAX_LEN_W-1:0] MAX_LINE_RESET = MAX_LEN_W'(256);
  localparam logic [CMP_W-1:0]     MIN_LF_INDEX   = CMP_W'(10);

  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_RES_BYTE = 3'd1,
    EV_ACCEPT   = 3'd2,
    EV_HDR_END  = 3'd3,
    EV_BODY     = 3'd4,
    EV_ERROR    = 3'd5
  } event_t;

  typedef enum logic {
    KIND_DATA  = 1'b0,
    KIND_START = 1'b1
  } kind_t;

  typedef enum logic [5:0] {
    PH_METHOD    = 6'b000001,
    PH_RESOURCE  = 6'b000010,
    PH_LINE_REST = 6'b000100,
    PH_HEADER    = 6'b001000,
    PH_BODY      = 6'b010000,
    PH_ERROR     = 6'b100000
  } phase_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] byte_in;
  } in_item_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic [7:0] byte_out;
    logic       method_code;
  } out_item_t;

  typedef struct packed {
    phase_t                     phase;
    logic                       method_seen;
    logic [2:0]                 match_position;
    logic [LINE_COUNT_BITS-1:0] line_count;
    logic                       line_nonempty;
  } parse_state_t;

  localparam parse_state_t STATE_CLEAR = '{
    phase:          PH_METHOD,
    method_seen:    1'b0,
    match_position: 3'd0,
    line_count:     '0,
    line_nonempty:  1'b0
  };

  function automatic logic [7:0] get_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h47;
      2'd1:    c = 8'h45;
      2'd2:    c = 8'h54;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] post_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h50;
      2'd1:    c = 8'h4f;
      2'd2:    c = 8'h53;
      default: c = 8'h54;
    endcase
    return c;
  endfunction

endpackage

// ===== hdl/hrp_step.sv =====
// per-byte next-state and result logic of the http request parser
// depends on hrp_pkg
module hrp_step (
  input  hrp_pkg::parse_state_t               cur_st,
  input  hrp_pkg::in_item_t                   item,
  input  logic [hrp_pkg::MAX_LEN_W-1:0]       max_len,
  output hrp_pkg::parse_state_t               nxt_st,
  output hrp_pkg::out_item_t                  result
);
  import hrp_pkg::*;

  always_comb begin
    logic [LINE_COUNT_BITS:0] n;
    logic [CMP_W-1:0]         n_cmp;
    logic [CMP_W-1:0]         max_cmp;
    logic [2:0]               pos;
    logic [2:0]               len;
    logic [7:0]               want;
    logic [7:0]               b;
    event_t                   ev;
    logic [7:0]               bo;

    nxt_st  = cur_st;
    b       = item.byte_in;
    ev      = EV_NONE;
    bo      = 8'h00;
    n       = {1'b0, cur_st.line_count} + {{LINE_COUNT_BITS{1'b0}}, 1'b1};
    n_cmp   = CMP_W'(n);
    max_cmp = CMP_W'(max_len);
    pos     = cur_st.match_position;
    len     = cur_st.method_seen ? 3'd4 : 3'd3;
    want    = cur_st.method_seen ? post_char(pos[1:0]) : get_char(pos[1:0]);

    if (item.kind == KIND_START) begin
      nxt_st = STATE_CLEAR;
    end else begin
      case (cur_st.phase)
        PH_METHOD, PH_RESOURCE, PH_LINE_REST: begin
          // request line count saturates at all ones
          nxt_st.line_count = n[LINE_COUNT_BITS] ? '1 : n[LINE_COUNT_BITS-1:0];
          if (b == CH_LF) begin
            if (cur_st.phase == PH_LINE_REST && n_cmp > MIN_LF_INDEX && n_cmp <= max_cmp) begin
              nxt_st.phase         = PH_HEADER;
              nxt_st.line_nonempty = 1'b0;
              ev                   = EV_ACCEPT;
            end else begin
              nxt_st.phase = PH_ERROR;
            end
          end else if (n_cmp >= max_cmp) begin
            nxt_st.phase = PH_ERROR;
          end else if (cur_st.phase == PH_METHOD) begin
            if (pos == 3'd0) begin
              if (b == CH_G) begin
                nxt_st.method_seen    = 1'b0;
                nxt_st.match_position = 3'd1;
              end else if (b == CH_P) begin
                nxt_st.method_seen    = 1'b1;
                nxt_st.match_position = 3'd1;
              end else begin
                nxt_st.phase = PH_ERROR;
              end
            end else if (pos < len) begin
              if (b != want) begin
                nxt_st.phase = PH_ERROR;
              end else begin
                nxt_st.match_position = pos + 3'd1;
              end
            end else if (pos == len && b == CH_SPACE) begin
              nxt_st.phase = PH_RESOURCE;
            end else begin
              nxt_st.phase = PH_ERROR;
            end
          end else if (cur_st.phase == PH_RESOURCE) begin
            if (b == CH_SPACE) begin
              nxt_st.phase = PH_LINE_REST;
            end else begin
              ev = EV_RES_BYTE;
              bo = b;
            end
          end
        end
        PH_HEADER: begin
          if (b == CH_LF) begin
            // a line with only cr/lf ends the header
            if (!cur_st.line_nonempty) begin
              nxt_st.phase = PH_BODY;
              ev           = EV_HDR_END;
            end
            nxt_st.line_nonempty = 1'b0;
          end else if (b != CH_CR) begin
            nxt_st.line_nonempty = 1'b1;
          end
        end
        PH_BODY: begin
          ev = EV_BODY;
          bo = b;
        end
        default: begin
          nxt_st.phase = PH_ERROR;
        end
      endcase

      if (nxt_st.phase == PH_ERROR) begin
        ev = EV_ERROR;
        bo = 8'h00;
      end
    end

    result.event_res   = ev;
    result.byte_out    = bo;
    result.method_code = nxt_st.method_seen;
  end

endmodule

// ===== hdl/http_request_header_parser.sv =====
// HTTP request line and header parser, one byte item per clock unless the result
// side stalls. An item enters an input register, the per-byte parse step runs from
// there into the result register, so the block takes one item every cycle while
// the result register is free or draining. The rate is set by the single registered
// parse step, so a stall on the result side is the only thing that holds the input.
// The length limit is written through cfg_we/cfg_wdata and resets to 256.
// depends on hrp_pkg, hrp_step and http_request_header_parser_assert.svh
module http_request_header_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  hrp_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output hrp_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [hrp_pkg::MAX_LEN_W-1:0] cfg_wdata
);
  import hrp_pkg::*;
  `include "http_request_header_parser_assert.svh"

  logic                 pipe_valid_r, pipe_valid_nxt;
  in_item_t             pipe_item_r, pipe_item_nxt;
  parse_state_t         st_r, st_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_item_r, out_item_nxt;
  logic [MAX_LEN_W-1:0] max_len_r, max_len_nxt;

  parse_state_t         step_st;
  out_item_t            step_res;
  logic                 advance;
  logic                 pipe_load;

  hrp_step u_step (
    .cur_st  (st_r),
    .item    (pipe_item_r),
    .max_len (max_len_r),
    .nxt_st  (step_st),
    .result  (step_res)
  );

  // input register moves on whenever the result register is free or draining
  assign advance   = pipe_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = pipe_valid_r && !advance;
  assign pipe_load = in_valid && !in_stall;

  always_comb begin
    pipe_valid_nxt = pipe_load || (pipe_valid_r && !advance);
    pipe_item_nxt  = pipe_load ? in_data : pipe_item_r;
    st_nxt         = advance ? step_st : st_r;
    out_valid_nxt  = advance || (out_valid_r && out_stall);
    out_item_nxt   = advance ? step_res : out_item_r;
    max_len_nxt    = cfg_we ? cfg_wdata : max_len_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pipe_valid_r <= 1'b0;
      st_r         <= STATE_CLEAR;
      out_valid_r  <= 1'b0;
      max_len_r    <= MAX_LINE_RESET;
    end else begin
      pipe_valid_r <= pipe_valid_nxt;
      st_r         <= st_nxt;
      out_valid_r  <= out_valid_nxt;
      max_len_r    <= max_len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pipe_item_r <= pipe_item_nxt;
    out_item_r  <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  `HRP_ASSERT_IMPL(a_byte_only_for_data, clk, rst_n,
    out_valid_r && out_item_r.event_res != EV_RES_BYTE && out_item_r.event_res != EV_BODY,
    out_item_r.byte_out == 8'h00)
  `HRP_ASSERT_IMPL(a_accept_enters_header, clk, rst_n,
    out_valid_r && out_item_r.event_res == EV_ACCEPT, st_r.phase == PH_HEADER)
  `HRP_ASSERT_NEXT(a_start_clears, clk, rst_n, advance && pipe_item_r.kind == KIND_START,
    st_r.phase == PH_METHOD && st_r.line_count == '0 && out_item_r.event_res == EV_NONE)
  `HRP_ASSERT_IMPL(a_stall_only_when_full, clk, rst_n, in_stall,
    pipe_valid_r && out_valid_r && out_stall)

endmodule
